// File: design/ldgs_pkg.sv
package ldgs_pkg;

	localparam int LOG_TABLE_ENTRIES   = 256;
	localparam int DEPTH_FRACTION_BITS = 16;

	localparam int LOG_FRAC_BITS = 16;
	localparam int TAB_W         = LOG_FRAC_BITS + 1;
	localparam int TAB_IW        = $clog2(LOG_TABLE_ENTRIES + 1);
	localparam int EXP_W         = 6;
	localparam int LOG_W         = EXP_W + LOG_FRAC_BITS;
	localparam int DEPTH_W       = 32;
	localparam int EXT_W         = DEPTH_W + 1;
	localparam int INV_W         = 32;
	localparam int PROD_W        = LOG_W + INV_W;
	localparam int SHADE_W       = 8;
	localparam int SCALE_SHIFT   = 24;

	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam int ADDR_W  = 3;
	localparam logic REG_CLIP_NEAR = 1'b0;
	localparam logic REG_CLIP_FAR  = 1'b1;

	localparam logic [DEPTH_W-1:0] CLIP_NEAR_RST =
		DEPTH_W'(((64'(1) << DEPTH_FRACTION_BITS) + 64'(5)) / 64'(10));
	localparam logic [DEPTH_W-1:0] CLIP_FAR_RST =
		DEPTH_W'(64'(100) << DEPTH_FRACTION_BITS);

	localparam logic [INV_W-1:0] INV_DIVIDEND = INV_W'(64'(255) << SCALE_SHIFT);

	typedef logic [TAB_W-1:0] log_tab_t [0:LOG_TABLE_ENTRIES];

	typedef struct packed {
		logic               wr;
		logic [EXT_W-1:0]   near;
		logic [EXT_W-1:0]   far;
	} cfg_t;

	typedef struct packed {
		logic [EXT_W-1:0]   v;
		logic               ok;
		logic               last;
		logic [DEPTH_W-1:0] min_d;
		logic [DEPTH_W-1:0] max_d;
	} q_entry_t;

	function automatic log_tab_t build_log_table();
		log_tab_t         t;
		logic [63:0]      y;
		logic [TAB_W-1:0] res;
		for (int k = 0; k < LOG_TABLE_ENTRIES; k++) begin
			y   = (64'(1) << 30) + ((64'(k) << 30) / 64'(LOG_TABLE_ENTRIES));
			res = '0;
			for (int b = LOG_FRAC_BITS - 1; b >= 0; b--) begin
				y = (y * y) >> 30;
				if (y >= (64'(1) << 31)) begin
					y      = y >> 1;
					res[b] = 1'b1;
				end
			end
			t[k] = res;
		end
		t[LOG_TABLE_ENTRIES] = TAB_W'(64'(1) << LOG_FRAC_BITS);
		return t;
	endfunction

	localparam log_tab_t LOG_TABLE = build_log_table();

endpackage

// File: design/ldgs_front.sv
module ldgs_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ldgs_pkg::ADDR_W-1:0]       paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	input  logic                              pixel_valid,
	output logic                              pixel_ready,
	input  logic [ldgs_pkg::DEPTH_W-1:0]      depth,
	input  logic                              depth_finite,
	input  logic                              last_pixel,
	output ldgs_pkg::cfg_t                    cfg,
	output logic                              push,
	output ldgs_pkg::q_entry_t                push_data,
	input  logic                              q_full
);

	logic [ldgs_pkg::DEPTH_W-1:0] clip_near_q, clip_far_q;
	logic [ldgs_pkg::DEPTH_W-1:0] min_q, max_q;
	logic                         seen_q;
	logic                         wr;
	logic [ldgs_pkg::EXT_W-1:0]   near, far, d_ext;
	logic                         ok;
	logic [ldgs_pkg::DEPTH_W-1:0] min_n, max_n;
	logic                         seen_n;

	assign wr     = psel & penable & pwrite;
	assign prdata = (paddr[2] == ldgs_pkg::REG_CLIP_FAR) ? clip_far_q : clip_near_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_near_q <= ldgs_pkg::CLIP_NEAR_RST;
			clip_far_q  <= ldgs_pkg::CLIP_FAR_RST;
		end else if (wr) begin
			case (paddr[2])
				ldgs_pkg::REG_CLIP_NEAR: clip_near_q <= pwdata;
				ldgs_pkg::REG_CLIP_FAR:  clip_far_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		near = (clip_near_q == '0) ? ldgs_pkg::EXT_W'(1) : {1'b0, clip_near_q};
		far  = ({1'b0, clip_far_q} > near) ? {1'b0, clip_far_q} : near + ldgs_pkg::EXT_W'(1);
	end

	assign cfg.wr   = wr;
	assign cfg.near = near;
	assign cfg.far  = far;

	assign pixel_ready = !q_full;
	assign push        = pixel_valid & pixel_ready;
	assign d_ext       = {1'b0, depth};
	assign ok          = depth_finite && (depth != '0);

	always_comb begin
		min_n  = (ok && depth < min_q) ? depth : min_q;
		max_n  = (ok && depth > max_q) ? depth : max_q;
		seen_n = seen_q | ok;
		push_data.ok    = ok;
		push_data.last  = last_pixel;
		push_data.v     = (d_ext < near) ? near : ((d_ext > far) ? far : d_ext);
		push_data.min_d = (last_pixel && seen_n) ? min_n : '0;
		push_data.max_d = (last_pixel && seen_n) ? max_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= '1;
			max_q  <= '0;
			seen_q <= 1'b0;
		end else if (push) begin
			if (last_pixel) begin
				min_q  <= '1;
				max_q  <= '0;
				seen_q <= 1'b0;
			end else begin
				min_q  <= min_n;
				max_q  <= max_n;
				seen_q <= seen_n;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full) else $error("word pushed into full queue");

	a_seen_tracks_max: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q |-> (max_q == '0 && min_q == '1)) else $error("extrema set without valid word");

endmodule

// File: design/ldgs_fifo.sv
module ldgs_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ldgs_pkg::q_entry_t push_data,
	output logic               full,
	input  logic               pop,
	output logic               pop_valid,
	output ldgs_pkg::q_entry_t pop_data
);

	ldgs_pkg::q_entry_t            slots_q [ldgs_pkg::Q_DEPTH];
	logic [ldgs_pkg::Q_AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [ldgs_pkg::Q_CW-1:0]     count_q;

	assign full      = (count_q == ldgs_pkg::Q_CW'(ldgs_pkg::Q_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = slots_q[rd_ptr_q];

	function automatic logic [ldgs_pkg::Q_AW-1:0] next_ptr(logic [ldgs_pkg::Q_AW-1:0] p);
		return (p == ldgs_pkg::Q_AW'(ldgs_pkg::Q_DEPTH - 1)) ? '0 : p + ldgs_pkg::Q_AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + ldgs_pkg::Q_CW'(1);
			else if (pop && !push)
				count_q <= count_q - ldgs_pkg::Q_CW'(1);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ldgs_pkg::Q_CW'(ldgs_pkg::Q_DEPTH)) else $error("queue overfilled");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid) else $error("pop from empty queue");

endmodule

// File: design/ldgs_log.sv
module ldgs_log (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        flush,
	input  logic                        start,
	input  logic [ldgs_pkg::EXT_W-1:0]  x,
	output logic                        done,
	output logic [ldgs_pkg::LOG_W-1:0]  result
);

	logic                              v_s1, v_s2, v_s3, v_s4;
	logic [ldgs_pkg::EXT_W-1:0]        x_s1;
	logic [ldgs_pkg::EXP_W-1:0]        e_s1, e_s2, e_s3;
	logic [ldgs_pkg::TAB_W-1:0]        lo_s2, lo_s3, diff_s2, interp_s3;
	logic [31:0]                       r_s2;
	logic [ldgs_pkg::LOG_W-1:0]        res_s4;

	logic [ldgs_pkg::EXP_W-1:0]        e_c;
	logic [ldgs_pkg::EXT_W-1:0]        norm;
	logic [63:0]                       p;
	logic [ldgs_pkg::TAB_IW-1:0]       idx;
	logic [ldgs_pkg::TAB_W+31:0]       prod;

	always_comb begin
		e_c = '0;
		for (int b = 0; b < ldgs_pkg::EXT_W; b++)
			if (x[b])
				e_c = ldgs_pkg::EXP_W'(b);
	end

	always_comb begin
		norm = x_s1 << (ldgs_pkg::EXP_W'(32) - e_s1);
		p    = 64'(norm[31:0]) * 64'(ldgs_pkg::LOG_TABLE_ENTRIES);
		idx  = ldgs_pkg::TAB_IW'(p >> 32);
		if (idx >= ldgs_pkg::TAB_IW'(ldgs_pkg::LOG_TABLE_ENTRIES))
			idx = ldgs_pkg::TAB_IW'(ldgs_pkg::LOG_TABLE_ENTRIES - 1);
		prod = diff_s2 * r_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (flush) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		x_s1      <= x;
		e_s1      <= e_c;
		e_s2      <= e_s1;
		lo_s2     <= ldgs_pkg::LOG_TABLE[idx];
		diff_s2   <= ldgs_pkg::LOG_TABLE[idx + ldgs_pkg::TAB_IW'(1)] - ldgs_pkg::LOG_TABLE[idx];
		r_s2      <= p[31:0];
		e_s3      <= e_s2;
		lo_s3     <= lo_s2;
		interp_s3 <= prod[32 +: ldgs_pkg::TAB_W];
		res_s4    <= {e_s3, ldgs_pkg::LOG_FRAC_BITS'(0)} + ldgs_pkg::LOG_W'(lo_s3)
			+ ldgs_pkg::LOG_W'(interp_s3);
	end

	assign done   = v_s4;
	assign result = res_s4;

endmodule

// File: design/ldgs_back.sv
module ldgs_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ldgs_pkg::cfg_t                cfg,
	input  logic                          q_valid,
	input  ldgs_pkg::q_entry_t            q_data,
	output logic                          pop,
	output logic                          shade_valid,
	input  logic                          shade_ready,
	output logic [ldgs_pkg::SHADE_W-1:0]  shade,
	output logic                          frame_done,
	output logic [ldgs_pkg::DEPTH_W-1:0]  min_depth,
	output logic [ldgs_pkg::DEPTH_W-1:0]  max_depth
);

	typedef enum logic [3:0] {
		ST_LN, ST_LN_W, ST_LF_W, ST_DIV, ST_IDLE, ST_LV_W, ST_MUL, ST_SCALE, ST_OUT
	} state_t;

	state_t                              state_q;
	ldgs_pkg::q_entry_t                  item_q;
	logic [ldgs_pkg::LOG_W-1:0]          ln_q, d_q, rem_q, num_q;
	logic [ldgs_pkg::INV_W-1:0]          inv_q, quo_q;
	logic [4:0]                          cnt_q;
	logic [ldgs_pkg::PROD_W-1:0]         prod_q;
	logic [ldgs_pkg::SHADE_W-1:0]        shd_q;

	logic                                log_start, log_done;
	logic [ldgs_pkg::EXT_W-1:0]          log_x;
	logic [ldgs_pkg::LOG_W-1:0]          log_res, span;
	logic [ldgs_pkg::LOG_W:0]            rem_sh;
	logic                                qbit;
	logic [ldgs_pkg::PROD_W:0]           rounded;
	logic [ldgs_pkg::PROD_W-ldgs_pkg::SCALE_SHIFT:0] scaled;
	logic [ldgs_pkg::SHADE_W-1:0]        sat;
	logic                                out_fire;

	ldgs_log u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.flush  (cfg.wr),
		.start  (log_start),
		.x      (log_x),
		.done   (log_done),
		.result (log_res)
	);

	assign pop      = (state_q == ST_IDLE) && q_valid && !cfg.wr;
	assign out_fire = !cfg.wr && (state_q == ST_OUT) && (!shade_valid || shade_ready);

	always_comb begin
		log_start = 1'b0;
		log_x     = cfg.near;
		case (state_q)
			ST_LN: log_start = 1'b1;
			ST_LN_W: begin
				log_start = log_done;
				log_x     = cfg.far;
			end
			ST_IDLE: begin
				log_start = pop && q_data.ok;
				log_x     = q_data.v;
			end
			default: ;
		endcase
	end

	always_comb begin
		span    = (log_res > ln_q) ? log_res - ln_q : '0;
		rem_sh  = {rem_q, quo_q[ldgs_pkg::INV_W-1]};
		qbit    = (rem_sh >= {1'b0, d_q});
		rounded = {1'b0, prod_q} + (ldgs_pkg::PROD_W+1)'(64'(1) << (ldgs_pkg::SCALE_SHIFT - 1));
		scaled  = rounded[ldgs_pkg::PROD_W:ldgs_pkg::SCALE_SHIFT];
		sat     = (scaled > (ldgs_pkg::PROD_W-ldgs_pkg::SCALE_SHIFT+1)'(255)) ? '1
			: scaled[ldgs_pkg::SHADE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop)
			item_q <= q_data;
		if (state_q == ST_LV_W && log_done)
			num_q <= (log_res > ln_q) ? log_res - ln_q : '0;
		if (state_q == ST_MUL)
			prod_q <= num_q * inv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LN;
			ln_q        <= '0;
			d_q         <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			cnt_q       <= '0;
			inv_q       <= '0;
			shd_q       <= '0;
			shade_valid <= 1'b0;
			shade       <= '0;
			frame_done  <= 1'b0;
			min_depth   <= '0;
			max_depth   <= '0;
		end else begin
			if (out_fire)
				shade_valid <= 1'b1;
			else if (shade_ready)
				shade_valid <= 1'b0;
			if (cfg.wr) begin
				state_q <= ST_LN;
			end else begin
				case (state_q)
					ST_LN: state_q <= ST_LN_W;
					ST_LN_W: begin
						if (log_done) begin
							ln_q    <= log_res;
							state_q <= ST_LF_W;
						end
					end
					ST_LF_W: begin
						if (log_done) begin
							d_q   <= span;
							rem_q <= '0;
							quo_q <= ldgs_pkg::INV_DIVIDEND;
							cnt_q <= '0;
							if (span == '0) begin
								inv_q   <= '0;
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_DIV;
							end
						end
					end
					ST_DIV: begin
						rem_q <= qbit ? ldgs_pkg::LOG_W'(rem_sh - {1'b0, d_q})
							: rem_sh[ldgs_pkg::LOG_W-1:0];
						quo_q <= {quo_q[ldgs_pkg::INV_W-2:0], qbit};
						cnt_q <= cnt_q + 5'd1;
						if (cnt_q == 5'd31) begin
							inv_q   <= {quo_q[ldgs_pkg::INV_W-2:0], qbit};
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (pop) begin
							if (q_data.ok) begin
								state_q <= ST_LV_W;
							end else begin
								shd_q   <= '0;
								state_q <= ST_OUT;
							end
						end
					end
					ST_LV_W: begin
						if (log_done)
							state_q <= ST_MUL;
					end
					ST_MUL: state_q <= ST_SCALE;
					ST_SCALE: begin
						shd_q   <= sat;
						state_q <= ST_OUT;
					end
					ST_OUT: begin
						if (out_fire) begin
							shade       <= shd_q;
							frame_done  <= item_q.last;
							min_depth   <= item_q.min_d;
							max_depth   <= item_q.max_d;
							state_q     <= ST_IDLE;
						end
					end
					default: state_q <= ST_LN;
				endcase
			end
		end
	end

	a_log_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		log_done |-> (state_q == ST_LN_W || state_q == ST_LF_W || state_q == ST_LV_W))
		else $error("log result with no one waiting");

	a_extrema_only_on_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(shade_valid && !frame_done) |-> (min_depth == '0 && max_depth == '0))
		else $error("extrema on a word that does not close a frame");

	a_no_pop_during_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_LN || state_q == ST_LN_W || state_q == ST_LF_W)
		|-> !pop) else $error("word taken before scale factor ready");

endmodule

// File: design/log_depth_to_gray_shade_top.sv
// Logarithmic depth-to-gray shader: one Q16.16 depth word in, one 8-bit gray word out,
// with frame min/max depth reported on the word marked last. A valid pixel passes through
// the back end by pop, four-stage log2 pipeline, multiply, round and saturate, output; an
// invalid one by pop and output. The back end takes no new pixel until the last is output;
// the log2 pipeline is shared with setup. A two-entry queue lets pixels be taken while the
// back end is busy or a result waits. After reset and after every register write the back
// end derives the scale factor (two log2 runs, a 32-step divide); pixels queue unshaded.
module log_depth_to_gray_shade_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ldgs_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          pixel_valid,
	output logic                          pixel_ready,
	input  logic [ldgs_pkg::DEPTH_W-1:0]  depth,
	input  logic                          depth_finite,
	input  logic                          last_pixel,
	output logic                          shade_valid,
	input  logic                          shade_ready,
	output logic [ldgs_pkg::SHADE_W-1:0]  shade,
	output logic                          frame_done,
	output logic [ldgs_pkg::DEPTH_W-1:0]  min_depth,
	output logic [ldgs_pkg::DEPTH_W-1:0]  max_depth
);

	ldgs_pkg::cfg_t     cfg;
	ldgs_pkg::q_entry_t push_data, pop_data;
	logic               push, pop, q_full, q_valid;

	assign pready = 1'b1;

	ldgs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.depth        (depth),
		.depth_finite (depth_finite),
		.last_pixel   (last_pixel),
		.cfg          (cfg),
		.push         (push),
		.push_data    (push_data),
		.q_full       (q_full)
	);

	ldgs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_data  (pop_data)
	);

	ldgs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.q_valid     (q_valid),
		.q_data      (pop_data),
		.pop         (pop),
		.shade_valid (shade_valid),
		.shade_ready (shade_ready),
		.shade       (shade),
		.frame_done  (frame_done),
		.min_depth   (min_depth),
		.max_depth   (max_depth)
	);

endmodule
